@@ hdl/ball_beam_cascade_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ball beam cascade controller checker.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BALL_BEAM_CASCADE_CONTROLLER_ASSERT_SVH
`define BALL_BEAM_CASCADE_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define BBCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbcc check failed");

// Next-cycle implication
`define BBCC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbcc check failed");

`endif

@@ hdl/bbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbcc_pkg
// Shared types and constants of the ball beam cascade controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcc_pkg;

    // Command codes carried on s_tuser
    localparam int CMD_W = 2;
    typedef enum logic [CMD_W-1:0] {
        CMD_OUTER = 2'd0,
        CMD_INNER = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_t;

    // Configuration register map
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_EMA_ALPHA     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTER_KP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTER_KD      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_MAX     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_FF_GAIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_KP      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MAX     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY      = 3'd7;

    localparam int ANGLE_MAX_W = 13;

    localparam logic [CFG_DATA_W-1:0]  RST_EMA_ALPHA     = 16'd16384;
    localparam logic [CFG_DATA_W-1:0]  RST_OUTER_KP      = 16'd256;
    localparam logic [CFG_DATA_W-1:0]  RST_OUTER_KD      = 16'd0;
    localparam logic [ANGLE_MAX_W-1:0] RST_ANGLE_MAX     = 13'd1024;
    localparam logic [CFG_DATA_W-1:0]  RST_ACCEL_FF_GAIN = 16'd0;
    localparam logic [CFG_DATA_W-1:0]  RST_INNER_KP      = 16'd256;
    localparam logic [CFG_DATA_W-1:0]  RST_SPEED_MAX     = 16'd4096;
    localparam logic [CFG_DATA_W-1:0]  RST_MAX_DUTY      = 16'd1000;

    // Input item layout on s_tdata (encoder field and index flag follow)
    localparam int IN_W        = 16;
    localparam int S_POS_LSB   = 0;
    localparam int S_VEL_LSB   = 16;
    localparam int S_SEEN_BIT  = 32;
    localparam int S_ACC_LSB   = 33;
    localparam int S_TGT_LSB   = 49;
    localparam int S_ENC_LSB   = 65;

    // Result layout on m_tdata
    localparam int DUTY_OUT_W  = 16;
    localparam int TILT_W      = 14;
    localparam int POS_W       = 16;
    localparam int M_DIR_BIT   = 16;
    localparam int M_EN_BIT    = 17;
    localparam int M_DATA_W    = 48;

    // Internal value widths
    localparam int TARGET_W    = 8;
    localparam logic signed [IN_W-1:0] TARGET_LIMIT = 16'sd125;
    localparam int FF_W        = 32;
    localparam int SPEED_W     = 17;

    // Shared multiplier and accumulator
    localparam int MUL_A_W     = 18;
    localparam int MUL_B_W     = 17;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 36;
    localparam logic signed [ACC_W-1:0]   ROUND_Q8  = 36'sd128;
    localparam logic signed [MUL_P_W-1:0] ROUND_Q16 = 35'sd32768;

    // Serial divider request and response
    localparam int DIV_DIVIDEND_W = 32;
    localparam int DIV_DIVISOR_W  = 16;
    localparam int DIV_QUOT_W     = 16;

    typedef struct packed {
        logic                      start;
        logic [DIV_DIVIDEND_W-1:0] dividend;
        logic [DIV_DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/bbcc_mul.sv @@
// ----------------------------------------------------------------------------
// bbcc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcc_mul
(
    input  wire logic                                  clk,
    input  wire logic signed [bbcc_pkg::MUL_A_W-1:0]   a,
    input  wire logic signed [bbcc_pkg::MUL_B_W-1:0]   b,
    output logic signed      [bbcc_pkg::MUL_P_W-1:0]   p
);

    logic signed [bbcc_pkg::MUL_P_W-1:0] p_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ hdl/bbcc_div.sv @@
// ----------------------------------------------------------------------------
// bbcc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcc_div
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bbcc_pkg::div_req_t  req,
    output bbcc_pkg::div_rsp_t       rsp
);

    localparam int CntW = $clog2(bbcc_pkg::DIV_DIVIDEND_W);
    localparam logic [CntW-1:0] CntLast = CntW'(bbcc_pkg::DIV_DIVIDEND_W - 1);

    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic [CntW-1:0]                       count_reg, count_next;
    logic [bbcc_pkg::DIV_DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [bbcc_pkg::DIV_DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [bbcc_pkg::DIV_DIVISOR_W-1:0]    dvs_reg, dvs_next;
    logic [bbcc_pkg::DIV_DIVISOR_W:0]      shifted;
    logic                                  fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[bbcc_pkg::DIV_DIVIDEND_W-1]};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Load on start, then shift one bit per cycle
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? bbcc_pkg::DIV_DIVISOR_W'(shifted - {1'b0, dvs_reg})
                              : shifted[bbcc_pkg::DIV_DIVISOR_W-1:0];
            quo_next   = {quo_reg[bbcc_pkg::DIV_DIVIDEND_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CntLast)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[bbcc_pkg::DIV_QUOT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/ball_beam_cascade_controller.sv @@
// ----------------------------------------------------------------------------
// ball_beam_cascade_controller
// Cascaded PD position / P angle controller for a ball balancing beam.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request: s_tuser is the command (outer tick, inner tick,
//   stop, init) and s_tdata the sensor fields. Every request yields exactly
//   one result on m_* with duty, direction, drive enable, tilt target and
//   filtered position. cfg_* writes one gain or limit register per request
//   and is always ready; write it only while the block is idle.
//   One request is worked on at a time through a shared multiplier and a
//   one-bit-per-cycle divider, so s_tready is low while it runs.
//   Stop, init and ignored inner ticks go from dispatch to the result step;
//   an outer tick updates the filtered position and, with a ball, runs the
//   PD and feed-forward steps; an active inner tick waits for the divider.
//   The output register lets the next request be accepted while a result
//   waits; if m_tready stays low, the following result holds in its last
//   step until the register frees up.
//   Reset loads the register defaults, clears the controller state, marks
//   the next outer tick as the first position sample and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ball_beam_cascade_controller
#(
    parameter  int ENCODER_BITS = 14,
    parameter  int DUTY_WIDTH   = 16,
    localparam int S_DATA_W     = ((bbcc_pkg::S_ENC_LSB + ENCODER_BITS + 1 + 7) / 8) * 8
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // ball_pos, ball_vel, ball_seen, car_accel, target_mm, enc_angle, index_seen
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [S_DATA_W-1:0]                 s_tdata,
    // cmd
    input  wire logic [bbcc_pkg::CMD_W-1:0]          s_tuser,
    // duty, dir_positive, drive_enable, tilt_target, pos_filtered
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bbcc_pkg::M_DATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bbcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bbcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IdxBit = bbcc_pkg::S_ENC_LSB + ENCODER_BITS;
    localparam logic [ENCODER_BITS-1:0] EncHalf = {1'b1, {(ENCODER_BITS-1){1'b0}}};
    localparam logic [bbcc_pkg::DUTY_OUT_W-1:0] DutyMax =
        bbcc_pkg::DUTY_OUT_W'((1 << DUTY_WIDTH) - 1);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_DISPATCH  = 14'h0002,
        ST_FILT_ADD  = 14'h0004,
        ST_KP_MUL    = 14'h0008,
        ST_KD_MUL    = 14'h0010,
        ST_FF_MUL    = 14'h0020,
        ST_TILT      = 14'h0040,
        ST_IN_MUL    = 14'h0080,
        ST_IN_SUM    = 14'h0100,
        ST_SPEED     = 14'h0200,
        ST_MAG_MUL   = 14'h0400,
        ST_DIV_START = 14'h0800,
        ST_DIV_WAIT  = 14'h1000,
        ST_DONE      = 14'h2000
    } state_t;

    // Configuration registers
    logic [bbcc_pkg::CFG_DATA_W-1:0]   ema_alpha_reg;
    logic [bbcc_pkg::CFG_DATA_W-1:0]   outer_kp_reg;
    logic [bbcc_pkg::CFG_DATA_W-1:0]   outer_kd_reg;
    logic [bbcc_pkg::ANGLE_MAX_W-1:0]  angle_max_reg;
    logic [bbcc_pkg::CFG_DATA_W-1:0]   accel_ff_gain_reg;
    logic [bbcc_pkg::CFG_DATA_W-1:0]   inner_kp_reg;
    logic [bbcc_pkg::CFG_DATA_W-1:0]   speed_max_reg;
    logic [bbcc_pkg::CFG_DATA_W-1:0]   max_duty_reg;

    // Latched request
    bbcc_pkg::cmd_t                     item_cmd_reg;
    logic signed [bbcc_pkg::IN_W-1:0]   item_pos_reg;
    logic signed [bbcc_pkg::IN_W-1:0]   item_vel_reg;
    logic                               item_seen_reg;
    logic signed [bbcc_pkg::IN_W-1:0]   item_acc_reg;
    logic signed [bbcc_pkg::IN_W-1:0]   item_tgt_reg;
    logic [ENCODER_BITS-1:0]            item_enc_reg;
    logic                               item_idx_reg;

    // Controller state
    state_t                                  state_reg, state_next;
    logic                                    first_reg, first_next;
    logic signed [bbcc_pkg::POS_W-1:0]       pos_filt_reg, pos_filt_next;
    logic signed [bbcc_pkg::IN_W-1:0]        vel_hold_reg, vel_hold_next;
    logic signed [bbcc_pkg::TARGET_W-1:0]    target_reg, target_next;
    logic signed [bbcc_pkg::TILT_W-1:0]      tilt_goal_reg, tilt_goal_next;
    logic signed [bbcc_pkg::FF_W-1:0]        ff_reg, ff_next;
    logic [ENCODER_BITS-1:0]                 angle_zero_reg, angle_zero_next;
    logic                                    stepper_on_reg, stepper_on_next;
    logic [DUTY_WIDTH-1:0]                   duty_reg, duty_next;
    logic                                    dir_reg, dir_next;
    logic signed [bbcc_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic signed [bbcc_pkg::SPEED_W-1:0]     speed_reg, speed_next;
    logic                                    m_tvalid_reg, m_tvalid_next;
    logic [bbcc_pkg::M_DATA_W-1:0]           out_data_reg, out_data_next;

    // Datapath signals
    logic                                    s_accept;
    logic signed [bbcc_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [bbcc_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [bbcc_pkg::MUL_P_W-1:0]     mul_p;
    logic signed [bbcc_pkg::MUL_P_W-1:0]     filt_sum;
    logic signed [bbcc_pkg::POS_W-1:0]       filt_delta;
    logic signed [bbcc_pkg::TARGET_W-1:0]    tgt_clamped;
    logic signed [bbcc_pkg::ACC_W-1:0]       acc_q;
    logic signed [bbcc_pkg::TILT_W-1:0]      tilt_lim;
    logic signed [bbcc_pkg::TILT_W-1:0]      tilt_clamped;
    logic signed [bbcc_pkg::SPEED_W-1:0]     spd_lim;
    logic signed [bbcc_pkg::SPEED_W-1:0]     speed_clamped;
    logic [bbcc_pkg::DUTY_OUT_W-1:0]         speed_mag;
    logic [ENCODER_BITS-1:0]                 angle_raw;
    logic signed [ENCODER_BITS:0]            angle_s;
    logic [bbcc_pkg::DUTY_OUT_W-1:0]         duty_sat;
    bbcc_pkg::div_req_t                      div_req;
    bbcc_pkg::div_rsp_t                      div_rsp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_alpha_reg     <= bbcc_pkg::RST_EMA_ALPHA;
            outer_kp_reg      <= bbcc_pkg::RST_OUTER_KP;
            outer_kd_reg      <= bbcc_pkg::RST_OUTER_KD;
            angle_max_reg     <= bbcc_pkg::RST_ANGLE_MAX;
            accel_ff_gain_reg <= bbcc_pkg::RST_ACCEL_FF_GAIN;
            inner_kp_reg      <= bbcc_pkg::RST_INNER_KP;
            speed_max_reg     <= bbcc_pkg::RST_SPEED_MAX;
            max_duty_reg      <= bbcc_pkg::RST_MAX_DUTY;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bbcc_pkg::REG_EMA_ALPHA:     ema_alpha_reg     <= cfg_data;
                bbcc_pkg::REG_OUTER_KP:      outer_kp_reg      <= cfg_data;
                bbcc_pkg::REG_OUTER_KD:      outer_kd_reg      <= cfg_data;
                bbcc_pkg::REG_ANGLE_MAX:
                    angle_max_reg <= cfg_data[bbcc_pkg::ANGLE_MAX_W-1:0];
                bbcc_pkg::REG_ACCEL_FF_GAIN: accel_ff_gain_reg <= cfg_data;
                bbcc_pkg::REG_INNER_KP:      inner_kp_reg      <= cfg_data;
                bbcc_pkg::REG_SPEED_MAX:     speed_max_reg     <= cfg_data;
                bbcc_pkg::REG_MAX_DUTY:      max_duty_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_cmd_reg  <= bbcc_pkg::cmd_t'(s_tuser);
            item_pos_reg  <= s_tdata[bbcc_pkg::S_POS_LSB +: bbcc_pkg::IN_W];
            item_vel_reg  <= s_tdata[bbcc_pkg::S_VEL_LSB +: bbcc_pkg::IN_W];
            item_seen_reg <= s_tdata[bbcc_pkg::S_SEEN_BIT];
            item_acc_reg  <= s_tdata[bbcc_pkg::S_ACC_LSB +: bbcc_pkg::IN_W];
            item_tgt_reg  <= s_tdata[bbcc_pkg::S_TGT_LSB +: bbcc_pkg::IN_W];
            item_enc_reg  <= s_tdata[bbcc_pkg::S_ENC_LSB +: ENCODER_BITS];
            item_idx_reg  <= s_tdata[IdxBit];
        end
    end

    // Clamp the target, round the filter step, wrap the encoder angle
    always_comb
    begin
        if (item_tgt_reg > bbcc_pkg::TARGET_LIMIT)
            tgt_clamped = bbcc_pkg::TARGET_W'(bbcc_pkg::TARGET_LIMIT);
        else if (item_tgt_reg < -bbcc_pkg::TARGET_LIMIT)
            tgt_clamped = bbcc_pkg::TARGET_W'(-bbcc_pkg::TARGET_LIMIT);
        else
            tgt_clamped = bbcc_pkg::TARGET_W'(item_tgt_reg);

        filt_sum   = mul_p + bbcc_pkg::ROUND_Q16;
        filt_delta = bbcc_pkg::POS_W'(filt_sum >>> 16);

        angle_raw  = item_enc_reg - angle_zero_reg;
        angle_s    = (angle_raw > EncHalf) ? $signed({1'b1, angle_raw})
                                           : $signed({1'b0, angle_raw});
    end

    // Scale the accumulator and limit tilt and speed
    always_comb
    begin
        acc_q    = acc_reg >>> 8;
        tilt_lim = $signed({1'b0, angle_max_reg});
        spd_lim  = $signed({1'b0, speed_max_reg});

        if (acc_q > tilt_lim)
            tilt_clamped = tilt_lim;
        else if (acc_q < -tilt_lim)
            tilt_clamped = -tilt_lim;
        else
            tilt_clamped = bbcc_pkg::TILT_W'(acc_q);

        if (acc_q > spd_lim)
            speed_clamped = spd_lim;
        else if (acc_q < -spd_lim)
            speed_clamped = -spd_lim;
        else
            speed_clamped = bbcc_pkg::SPEED_W'(acc_q);

        speed_mag = speed_reg[bbcc_pkg::SPEED_W-1]
                  ? bbcc_pkg::DUTY_OUT_W'(-speed_reg)
                  : bbcc_pkg::DUTY_OUT_W'(speed_reg);

        duty_sat  = (div_rsp.quotient > DutyMax) ? DutyMax : div_rsp.quotient;
    end

    // Select the multiplier operands for each step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DISPATCH:
            begin
                mul_a = bbcc_pkg::MUL_A_W'(item_pos_reg)
                      - bbcc_pkg::MUL_A_W'(pos_filt_reg);
                mul_b = $signed({1'b0, ema_alpha_reg});
            end
            ST_KP_MUL:
            begin
                mul_a = bbcc_pkg::MUL_A_W'($signed({target_reg, 4'b0000}))
                      - bbcc_pkg::MUL_A_W'(pos_filt_reg);
                mul_b = $signed({1'b0, outer_kp_reg});
            end
            ST_KD_MUL:
            begin
                mul_a = bbcc_pkg::MUL_A_W'(vel_hold_reg);
                mul_b = $signed({1'b0, outer_kd_reg});
            end
            ST_FF_MUL:
            begin
                mul_a = bbcc_pkg::MUL_A_W'(item_acc_reg);
                mul_b = $signed({1'b0, accel_ff_gain_reg});
            end
            ST_IN_MUL:
            begin
                mul_a = bbcc_pkg::MUL_A_W'(tilt_goal_reg)
                      - bbcc_pkg::MUL_A_W'(angle_s);
                mul_b = $signed({1'b0, inner_kp_reg});
            end
            ST_MAG_MUL:
            begin
                mul_a = bbcc_pkg::MUL_A_W'($signed({1'b0, speed_mag}));
                mul_b = $signed({1'b0, max_duty_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bbcc_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Start the duty division once |speed| * max_duty is in the product
    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = mul_p[bbcc_pkg::DIV_DIVIDEND_W-1:0];
        div_req.divisor  = speed_max_reg;
    end

    bbcc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequence the request through the shared units
    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        pos_filt_next   = pos_filt_reg;
        vel_hold_next   = vel_hold_reg;
        target_next     = target_reg;
        tilt_goal_next  = tilt_goal_reg;
        ff_next         = ff_reg;
        angle_zero_next = angle_zero_reg;
        stepper_on_next = stepper_on_reg;
        duty_next       = duty_reg;
        dir_next        = dir_reg;
        acc_next        = acc_reg;
        speed_next      = speed_reg;
        out_data_next   = out_data_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                case (item_cmd_reg)
                    bbcc_pkg::CMD_OUTER:
                    begin
                        target_next = tgt_clamped;
                        if (first_reg)
                        begin
                            first_next    = 1'b0;
                            pos_filt_next = item_pos_reg;
                            vel_hold_next = item_vel_reg;
                            state_next    = item_seen_reg ? ST_KP_MUL : ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FILT_ADD;
                        end
                    end
                    bbcc_pkg::CMD_INNER:
                    begin
                        state_next = stepper_on_reg ? ST_IN_MUL : ST_DONE;
                    end
                    bbcc_pkg::CMD_STOP:
                    begin
                        duty_next       = '0;
                        dir_next        = 1'b0;
                        stepper_on_next = 1'b0;
                        ff_next         = '0;
                        state_next      = ST_DONE;
                    end
                    bbcc_pkg::CMD_INIT:
                    begin
                        angle_zero_next = item_enc_reg;
                        target_next     = '0;
                        tilt_goal_next  = '0;
                        pos_filt_next   = '0;
                        vel_hold_next   = '0;
                        ff_next         = '0;
                        duty_next       = '0;
                        dir_next        = 1'b0;
                        stepper_on_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FILT_ADD:
            begin
                pos_filt_next = pos_filt_reg + filt_delta;
                vel_hold_next = item_vel_reg;
                state_next    = item_seen_reg ? ST_KP_MUL : ST_DONE;
            end
            ST_KP_MUL:
            begin
                state_next = ST_KD_MUL;
            end
            ST_KD_MUL:
            begin
                acc_next   = bbcc_pkg::ACC_W'(mul_p) + bbcc_pkg::ROUND_Q8;
                state_next = ST_FF_MUL;
            end
            ST_FF_MUL:
            begin
                acc_next   = acc_reg - bbcc_pkg::ACC_W'(mul_p);
                state_next = ST_TILT;
            end
            ST_TILT:
            begin
                ff_next         = bbcc_pkg::FF_W'(mul_p);
                tilt_goal_next  = tilt_clamped;
                stepper_on_next = 1'b1;
                state_next      = ST_DONE;
            end
            ST_IN_MUL:
            begin
                state_next = ST_IN_SUM;
            end
            ST_IN_SUM:
            begin
                acc_next   = bbcc_pkg::ACC_W'(mul_p) + bbcc_pkg::ACC_W'(ff_reg)
                           + bbcc_pkg::ROUND_Q8;
                state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                speed_next = speed_clamped;
                state_next = ST_MAG_MUL;
            end
            ST_MAG_MUL:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    duty_next = (speed_max_reg == '0) ? '0 : DUTY_WIDTH'(duty_sat);
                    dir_next  = ~speed_reg[bbcc_pkg::SPEED_W-1];
                    if (item_idx_reg)
                        angle_zero_next = item_enc_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_data_next = {pos_filt_reg, tilt_goal_reg, stepper_on_reg,
                                     dir_reg, bbcc_pkg::DUTY_OUT_W'(duty_reg)};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= 1'b1;
            pos_filt_reg   <= '0;
            vel_hold_reg   <= '0;
            target_reg     <= '0;
            tilt_goal_reg  <= '0;
            ff_reg         <= '0;
            angle_zero_reg <= '0;
            stepper_on_reg <= 1'b0;
            duty_reg       <= '0;
            dir_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            pos_filt_reg   <= pos_filt_next;
            vel_hold_reg   <= vel_hold_next;
            target_reg     <= target_next;
            tilt_goal_reg  <= tilt_goal_next;
            ff_reg         <= ff_next;
            angle_zero_reg <= angle_zero_next;
            stepper_on_reg <= stepper_on_next;
            duty_reg       <= duty_next;
            dir_reg        <= dir_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        speed_reg    <= speed_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ hdl/bbcc_checker.sv @@
// ----------------------------------------------------------------------------
// bbcc_checker
// Port-level checks of the ball beam cascade controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ball_beam_cascade_controller_assert.svh"

module bbcc_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bbcc_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result holds
    `BBCC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A request keeps the block busy for at least the next cycle
    `BBCC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // A new result only appears at the end of a request's work
    `BBCC_ASSERT_IMP(a_result_from_work, $rose(m_tvalid), $past(!s_tready))

    // With the drive off, duty and direction are zero
    `BBCC_ASSERT_IMP(a_off_means_idle_drive, m_tvalid && !m_tdata[bbcc_pkg::M_EN_BIT], m_tdata[bbcc_pkg::M_DIR_BIT:0] == '0)

endmodule

bind ball_beam_cascade_controller bbcc_checker u_bbcc_checker (.*);

`default_nettype wire
